FILE: design/cpp_pkg.sv
// Shared constants and control types for the column projection profile block.
package cpp_pkg;

  localparam int MaxColsDef = 1024;
  localparam int MaxRowsDef = 4096;

  localparam int KindW  = 2;
  localparam int PixW   = 8;
  localparam int QcolW  = 10;
  localparam int QrowW  = 12;
  localparam int WidthW = 11;

  localparam logic [KindW-1:0] KIND_PIXEL = 2'd0;
  localparam logic [KindW-1:0] KIND_QUERY = 2'd1;
  localparam logic [KindW-1:0] KIND_CLEAR = 2'd2;

  localparam logic [WidthW-1:0] WIDTH_RST = 11'd1024;

  localparam logic [PixW-1:0] INK_LEVEL   = 8'd0;
  localparam logic [PixW-1:0] BLANK_LEVEL = 8'd255;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic issue;        // item accepted: latch payload, start store read
    logic start_clear;  // zero peak and position
    logic clr_step;     // zero one store entry
    logic exec_pixel;   // write back incremented count for an ink pixel, advance position
    logic exec_query;   // load the result register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_free;     // result register can take a new item
    logic clr_last;     // sweep is at the last entry
  } status_t;

endpackage

FILE: design/cpp_in_if.sv
// Input channel: valid/ready handshake with one pixel, query or clear item.
interface cpp_in_if
  import cpp_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic [PixW-1:0]  pixel_value;
  logic [QcolW-1:0] query_column;
  logic [QrowW-1:0] query_row;

  modport source (output valid, kind, pixel_value, query_column, query_row, input ready);
  modport sink   (input valid, kind, pixel_value, query_column, query_row, output ready);
endinterface

FILE: design/cpp_out_if.sv
// Output channel: valid/ready handshake with one query result item.
interface cpp_out_if
  import cpp_pkg::*;
#(
  parameter int CntW = 13
) ();
  logic            valid;
  logic            ready;
  logic [CntW-1:0] column_count;
  logic [CntW-1:0] peak_count;
  logic [PixW-1:0] bar_pixel;

  modport source (output valid, column_count, peak_count, bar_pixel, input ready);
  modport sink   (input valid, column_count, peak_count, bar_pixel, output ready);
endinterface

FILE: design/column_projection_profile.sv
// Column projection profile: per-column ink counts of a raster pixel stream.
// Pixel item: store read, then write back; query item: store read, then result
// register load, which waits only while the previous result is still not taken.
// Clear item: start, then one store entry zeroed per cycle over all MAX_COLS entries.
// After reset the store is swept over all MAX_COLS entries before the first item is taken;
// configuration writes are taken at any time.
module column_projection_profile
  import cpp_pkg::*;
#(
  parameter int MAX_COLS = MaxColsDef,
  parameter int MAX_ROWS = MaxRowsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [WidthW-1:0] cfg_wdata_i,
  cpp_in_if.sink            in_i,
  cpp_out_if.source         out_o
);

  localparam int CntW = $clog2(MAX_ROWS + 1);

  cmd_t    cmd;
  status_t status;

  cpp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_kind_i  (in_i.kind),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cpp_dp #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .CntW     (CntW)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .kind_i         (in_i.kind),
    .pixel_value_i  (in_i.pixel_value),
    .query_column_i (in_i.query_column),
    .query_row_i    (in_i.query_row),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .column_count_o (out_o.column_count),
    .peak_count_o   (out_o.peak_count),
    .bar_pixel_o    (out_o.bar_pixel)
  );

endmodule

FILE: design/cpp_ctrl.sv
// Controller state machine: sequences accept, store access and clearing sweep.
module cpp_ctrl
  import cpp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [KindW-1:0] in_kind_i,
  output logic             in_ready_o,
  input  status_t          status_i,
  output cmd_t             cmd_o
);

  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;

  logic [1:0] state_q, state_d;
  logic       is_query_q, is_query_d;

  always_comb begin
    state_d    = state_q;
    is_query_d = is_query_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.issue = 1'b1;
          if (in_kind_i == KIND_PIXEL || in_kind_i == KIND_QUERY) begin
            is_query_d = (in_kind_i == KIND_QUERY);
            state_d    = ST_EXEC;
          end else if (in_kind_i == KIND_CLEAR) begin
            cmd_o.start_clear = 1'b1;
            state_d           = ST_CLR;
          end
        end
      end
      ST_EXEC: begin
        if (!is_query_q) begin
          cmd_o.exec_pixel = 1'b1;
          state_d          = ST_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.exec_query = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      ST_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLR;
      is_query_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      is_query_q <= is_query_d;
    end
  end

endmodule

FILE: design/cpp_dp.sv
// Datapath: count store, peak, column position, width register and result register.
module cpp_dp
  import cpp_pkg::*;
#(
  parameter int MAX_COLS = MaxColsDef,
  parameter int MAX_ROWS = MaxRowsDef,
  parameter int CntW     = $clog2(MAX_ROWS + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [WidthW-1:0] cfg_wdata_i,
  input  logic [KindW-1:0]  kind_i,
  input  logic [PixW-1:0]   pixel_value_i,
  input  logic [QcolW-1:0]  query_column_i,
  input  logic [QrowW-1:0]  query_row_i,
  input  cmd_t              cmd_i,
  output status_t           status_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [CntW-1:0]   column_count_o,
  output logic [CntW-1:0]   peak_count_o,
  output logic [PixW-1:0]   bar_pixel_o
);

  localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int WW = (AW + 1 > WidthW) ? AW + 1 : WidthW;
  localparam int CW = ((AW > QcolW) ? AW : QcolW) + 1;
  localparam int RW = (CntW > QrowW) ? CntW : QrowW;

  logic [CntW-1:0] mem [MAX_COLS];
  logic [CntW-1:0] rd_data_q;

  logic [WidthW-1:0] width_q;
  logic [AW-1:0]     pos_q, pos_d;
  logic [CntW-1:0]   peak_q, peak_d;
  logic [AW-1:0]     clr_idx_q;

  logic            pix_zero_q;
  logic            qcol_ok_q;
  logic [QrowW-1:0] qrow_q;

  logic            out_valid_q;
  logic [CntW-1:0] out_count_q, out_peak_q;
  logic [PixW-1:0] out_bar_q;

  logic [CW-1:0]   qcol_ext;
  logic            qcol_ok;
  logic [AW-1:0]   rd_addr;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [CntW-1:0] wr_data;
  logic [CntW-1:0] inc_count;
  logic [WW-1:0]   w_ext, act_w, pos_next;
  logic [CntW-1:0] q_count;
  logic [RW-1:0]   row_e, peak_e, cnt_e;
  logic            in_bar;

  assign qcol_ext = CW'(query_column_i);
  assign qcol_ok  = qcol_ext < CW'(MAX_COLS);
  assign rd_addr  = (kind_i == KIND_PIXEL) ? pos_q : qcol_ext[AW-1:0];

  // Saturating increment of the column count read back from the store
  assign inc_count = (rd_data_q < CntW'(MAX_ROWS)) ? rd_data_q + CntW'(1) : rd_data_q;

  assign wr_en   = cmd_i.clr_step | (cmd_i.exec_pixel & pix_zero_q);
  assign wr_addr = cmd_i.clr_step ? clr_idx_q : pos_q;
  assign wr_data = cmd_i.clr_step ? '0 : inc_count;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.issue) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // Clamp the configured width into one to MAX_COLS
  assign w_ext    = WW'(width_q);
  assign act_w    = (w_ext == '0) ? WW'(1) :
                    ((w_ext > WW'(MAX_COLS)) ? WW'(MAX_COLS) : w_ext);
  assign pos_next = WW'(pos_q) + WW'(1);

  always_comb begin
    pos_d  = pos_q;
    peak_d = peak_q;
    if (cmd_i.start_clear) begin
      pos_d  = '0;
      peak_d = '0;
    end else if (cmd_i.exec_pixel) begin
      pos_d = (pos_next >= act_w) ? '0 : pos_next[AW-1:0];
      if (pix_zero_q && inc_count > peak_q) begin
        peak_d = inc_count;
      end
    end
  end

  assign q_count = qcol_ok_q ? rd_data_q : '0;
  assign row_e   = RW'(qrow_q);
  assign peak_e  = RW'(peak_q);
  assign cnt_e   = RW'(q_count);
  assign in_bar  = (cnt_e != '0) && (row_e < peak_e) && (row_e >= peak_e - cnt_e);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= WIDTH_RST;
      pos_q       <= '0;
      peak_q      <= '0;
      clr_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        width_q <= cfg_wdata_i;
      end
      pos_q  <= pos_d;
      peak_q <= peak_d;
      if (cmd_i.clr_step) begin
        clr_idx_q <= status_o.clr_last ? '0 : clr_idx_q + AW'(1);
      end
      if (cmd_i.exec_query) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      pix_zero_q <= (pixel_value_i == '0);
      qcol_ok_q  <= qcol_ok;
      qrow_q     <= query_row_i;
    end
    if (cmd_i.exec_query) begin
      out_count_q <= q_count;
      out_peak_q  <= peak_q;
      out_bar_q   <= in_bar ? INK_LEVEL : BLANK_LEVEL;
    end
  end

  assign status_o.out_free = ~out_valid_q | out_ready_i;
  assign status_o.clr_last = (clr_idx_q == AW'(MAX_COLS - 1));

  assign out_valid_o    = out_valid_q;
  assign column_count_o = out_count_q;
  assign peak_count_o   = out_peak_q;
  assign bar_pixel_o    = out_bar_q;

endmodule

FILE: test/column_projection_profile_tb.sv
// Self-checking testbench for column_projection_profile: directed and random items.
module column_projection_profile_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cpp_pkg::*;

  localparam int ClkPeriod     = 10;
  localparam int CntW          = 13;
  localparam int IdlePct       = 26;
  localparam int HoldCycles    = 400;
  localparam int SettleCycles  = MaxColsDef + 16;
  localparam int WatchdogLimit = 8 * MaxColsDef;
  localparam int PhaseItems    = 65;
  localparam int TallItems     = 100;

  localparam logic [KindW-1:0]  KIND_UNUSED = 2'd3;
  localparam logic [PixW-1:0]   PIX_INK     = 8'd0;
  localparam logic [WidthW-1:0] WIDTH_MAX   = 11'd2047;
  localparam logic [WidthW-1:0] WIDTH_ZERO  = 11'd0;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [PixW-1:0]  pixel_value;
    logic [QcolW-1:0] query_column;
    logic [QrowW-1:0] query_row;
  } profile_item_t;

  typedef struct packed {
    logic [CntW-1:0] column_count;
    logic [CntW-1:0] peak_count;
    logic [PixW-1:0] bar_pixel;
  } bar_answer_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we;
  logic [WidthW-1:0] cfg_wdata;

  cpp_in_if                 in_bus ();
  cpp_out_if #(.CntW(CntW)) out_bus ();

  column_projection_profile i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_bus),
    .out_o      (out_bus)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Predicted profile state
  int unsigned       ink_tally [MaxColsDef];
  int unsigned       peak_tally;
  int unsigned       cursor;
  logic [WidthW-1:0] width_reg;
  bar_answer_t       pending_bars [$];

  int mismatch_count = 0;
  int quiet_cycles   = 0;
  int hold_asks      = 0;
  bit gaps_on        = 1'b1;

  function automatic int unsigned effective_width();
    if (width_reg == WIDTH_ZERO) return 1;
    if (width_reg > MaxColsDef) return MaxColsDef;
    return width_reg;
  endfunction

  function automatic void clear_profile();
    foreach (ink_tally[i]) ink_tally[i] = 0;
    peak_tally = 0;
    cursor     = 0;
  endfunction

  function automatic void advance_profile(profile_item_t it);
    bar_answer_t ans;
    int unsigned cnt;
    case (it.kind)
      KIND_PIXEL: begin
        if (it.pixel_value == PIX_INK) begin
          if (ink_tally[cursor] < MaxRowsDef) ink_tally[cursor]++;
          if (ink_tally[cursor] > peak_tally) peak_tally = ink_tally[cursor];
        end
        cursor = (cursor + 1 >= effective_width()) ? 0 : cursor + 1;
      end
      KIND_QUERY: begin
        cnt              = ink_tally[it.query_column];
        ans.column_count = CntW'(cnt);
        ans.peak_count   = CntW'(peak_tally);
        // Bars stand on the bottom row, so a bar covers rows peak - count .. peak - 1
        if (cnt != 0 && it.query_row < peak_tally && it.query_row >= peak_tally - cnt) begin
          ans.bar_pixel = INK_LEVEL;
        end else begin
          ans.bar_pixel = BLANK_LEVEL;
        end
        pending_bars = {pending_bars, ans};
      end
      KIND_CLEAR: clear_profile();
      default: ;
    endcase
  endfunction

  function automatic profile_item_t make_item(logic [KindW-1:0] kind, logic [PixW-1:0] pix,
                                              logic [QcolW-1:0] col, logic [QrowW-1:0] row);
    profile_item_t it;
    it.kind         = kind;
    it.pixel_value  = pix;
    it.query_column = col;
    it.query_row    = row;
    return it;
  endfunction

  function automatic profile_item_t random_item();
    profile_item_t it;
    int unsigned   pick;
    int unsigned   row_top;
    it   = make_item(KIND_PIXEL, PixW'($urandom_range(255)), QcolW'($urandom_range(1023)),
                     QrowW'($urandom_range(4095)));
    pick = $urandom_range(99);
    if (pick < 68) begin
      it.kind = KIND_PIXEL;
      if ($urandom_range(99) < 55) it.pixel_value = PIX_INK;
    end else if (pick < 94) begin
      it.kind = KIND_QUERY;
    end else if (pick < 96) begin
      it.kind = KIND_CLEAR;
    end else begin
      it.kind = KIND_UNUSED;
    end
    if ($urandom_range(99) < 80) begin
      it.query_column = QcolW'($urandom_range(effective_width() - 1));
    end
    // Aim most rows at the bar image so that bar edges are hit
    if (peak_tally != 0 && $urandom_range(99) < 75) begin
      row_top      = (peak_tally > 4095) ? 4095 : peak_tally;
      it.query_row = QrowW'($urandom_range(row_top));
    end
    return it;
  endfunction

  task automatic flag_mismatch(string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic send_item(profile_item_t it);
    @(negedge clk_i);
    while (gaps_on && $urandom_range(99) < IdlePct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid        <= 1'b1;
    in_bus.kind         <= it.kind;
    in_bus.pixel_value  <= it.pixel_value;
    in_bus.query_column <= it.query_column;
    in_bus.query_row    <= it.query_row;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    advance_profile(it);
  endtask

  // Drop valid, wait for every expected result, then let the block finish internal work
  task automatic settle_block(int extra);
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (pending_bars.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic configure(logic [WidthW-1:0] w);
    settle_block(SettleCycles);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    width_reg = w;
  endtask

  task automatic test_directed();
    send_item(make_item(KIND_QUERY, 8'd0, 10'd0, 12'd0));
    send_item(make_item(KIND_PIXEL, PIX_INK, 10'd1023, 12'd4095));
    send_item(make_item(KIND_PIXEL, 8'd255, 10'd0, 12'd0));
    send_item(make_item(KIND_PIXEL, PIX_INK, 10'd0, 12'd0));
    send_item(make_item(KIND_PIXEL, 8'h80, 10'd0, 12'd0));
    send_item(make_item(KIND_PIXEL, 8'h01, 10'd0, 12'd0));
    send_item(make_item(KIND_UNUSED, PIX_INK, 10'd1023, 12'd4095));
    send_item(make_item(KIND_QUERY, 8'd255, 10'd0, 12'd0));
    send_item(make_item(KIND_QUERY, 8'd0, 10'd1, 12'd0));
    send_item(make_item(KIND_QUERY, 8'd0, 10'd2, 12'd4095));
    send_item(make_item(KIND_QUERY, 8'd0, 10'd1023, 12'd4095));
    send_item(make_item(KIND_QUERY, 8'd0, 10'd0, 12'd1));
    send_item(make_item(KIND_CLEAR, PIX_INK, 10'd1023, 12'd4095));
    send_item(make_item(KIND_QUERY, 8'd0, 10'd0, 12'd0));
    send_item(make_item(KIND_PIXEL, PIX_INK, 10'd0, 12'd0));
    send_item(make_item(KIND_PIXEL, PIX_INK, 10'd0, 12'd0));
    send_item(make_item(KIND_QUERY, 8'd0, 10'd0, 12'd0));
    send_item(make_item(KIND_QUERY, 8'd0, 10'd1, 12'd0));
    send_item(make_item(KIND_QUERY, 8'd0, 10'd2, 12'd0));
  endtask

  task automatic test_width_clamp();
    configure(WIDTH_ZERO);
    send_item(make_item(KIND_CLEAR, 8'd0, 10'd0, 12'd0));
    repeat (3) send_item(make_item(KIND_PIXEL, PIX_INK, 10'd0, 12'd0));
    send_item(make_item(KIND_QUERY, 8'd0, 10'd0, 12'd0));
    send_item(make_item(KIND_QUERY, 8'd0, 10'd0, 12'd2));
    send_item(make_item(KIND_QUERY, 8'd0, 10'd0, 12'd3));
    send_item(make_item(KIND_QUERY, 8'd0, 10'd1, 12'd0));
    // Width above the store: position must wrap at the store size
    configure(WIDTH_MAX);
    repeat (MaxColsDef + 6) send_item(make_item(KIND_PIXEL, $urandom_range(1) ? PIX_INK : 8'd9,
                                                10'd0, 12'd0));
    for (int c = 0; c < 6; c++) send_item(make_item(KIND_QUERY, 8'd0, QcolW'(c), 12'd3));
    send_item(make_item(KIND_QUERY, 8'd0, 10'd1023, 12'd4));
  endtask

  task automatic test_width_lowered();
    configure(11'd8);
    send_item(make_item(KIND_CLEAR, 8'd0, 10'd0, 12'd0));
    repeat (5) send_item(make_item(KIND_PIXEL, PIX_INK, 10'd0, 12'd0));
    configure(11'd3);
    // Count lands on column 5, then the position wraps to zero
    send_item(make_item(KIND_PIXEL, PIX_INK, 10'd0, 12'd0));
    send_item(make_item(KIND_PIXEL, PIX_INK, 10'd0, 12'd0));
    send_item(make_item(KIND_QUERY, 8'd0, 10'd5, 12'd1));
    send_item(make_item(KIND_QUERY, 8'd0, 10'd0, 12'd0));
    send_item(make_item(KIND_QUERY, 8'd0, 10'd6, 12'd1));
    send_item(make_item(KIND_QUERY, 8'd0, 10'd1, 12'd1));
  endtask

  // One column takes every pixel, so its bar fills the whole image height
  task automatic test_tall_column();
    configure(11'd1);
    send_item(make_item(KIND_CLEAR, 8'd0, 10'd0, 12'd0));
    repeat (TallItems) send_item(make_item(KIND_PIXEL, PIX_INK, 10'd0, 12'd0));
    send_item(make_item(KIND_QUERY, 8'd0, 10'd0, 12'd0));
    send_item(make_item(KIND_QUERY, 8'd0, 10'd0, 12'd4095));
    send_item(make_item(KIND_QUERY, 8'd0, 10'd1, 12'd4095));
    send_item(make_item(KIND_PIXEL, 8'd255, 10'd0, 12'd0));
    send_item(make_item(KIND_QUERY, 8'd0, 10'd0, 12'd2048));
    send_item(make_item(KIND_CLEAR, 8'd0, 10'd0, 12'd0));
  endtask

  task automatic test_backpressure();
    profile_item_t it;
    configure(11'd4);
    repeat (40) send_item(make_item(KIND_PIXEL, $urandom_range(3) ? PIX_INK : 8'd77,
                                    10'd0, 12'd0));
    hold_asks++;
    // Keep offering queries so the block fills and stalls its input
    repeat (24) begin
      it      = random_item();
      it.kind = KIND_QUERY;
      send_item(it);
    end
    settle_block(0);
    repeat (10) send_item(random_item());
  endtask

  task automatic test_random();
    logic [WidthW-1:0] widths [6];
    widths = '{11'd3, 11'd1, 11'd16, WIDTH_RST, WIDTH_MAX, 11'd0};
    for (int p = 0; p < 6; p++) begin
      configure((p == 5) ? WidthW'($urandom_range(1, 2047)) : widths[p]);
      gaps_on = (p != 2);
      repeat (PhaseItems) send_item(random_item());
    end
    gaps_on = 1'b1;
  endtask

  initial begin : result_sink
    int hold_left;
    int hold_seen;
    hold_left     = 0;
    hold_seen     = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= !(gaps_on && $urandom_range(99) < IdlePct);
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    bar_answer_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (pending_bars.size() == 0) begin
        flag_mismatch("result item with no query waiting");
      end else begin
        want = pending_bars.pop_front();
        if (out_bus.column_count !== want.column_count)
          flag_mismatch($sformatf("column_count %0d, want %0d",
                                  out_bus.column_count, want.column_count));
        if (out_bus.peak_count !== want.peak_count)
          flag_mismatch($sformatf("peak_count %0d, want %0d",
                                  out_bus.peak_count, want.peak_count));
        if (out_bus.bar_pixel !== want.bar_pixel)
          flag_mismatch($sformatf("bar_pixel %0d, want %0d",
                                  out_bus.bar_pixel, want.bar_pixel));
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("TIMEOUT: no handshake for %0d cycles, %0d results outstanding",
               quiet_cycles, pending_bars.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : test_sequence
    rst_ni              = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    in_bus.valid        = 1'b0;
    in_bus.kind         = KIND_PIXEL;
    in_bus.pixel_value  = '0;
    in_bus.query_column = '0;
    in_bus.query_row    = '0;
    clear_profile();
    width_reg = WIDTH_RST;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_width_clamp();
    test_width_lowered();
    test_tall_column();
    test_backpressure();
    test_random();

    settle_block(SettleCycles);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
design/cpp_pkg.sv
design/cpp_in_if.sv
design/cpp_out_if.sv
design/cpp_ctrl.sv
design/cpp_dp.sv
design/column_projection_profile.sv
test/column_projection_profile_tb.sv
